[rtl/jcsl_pkg.sv]
// ----------------------------------------------------------------------------
// jcsl_pkg
// Shared types and constants for the junction corner speed limit pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package jcsl_pkg;

    // Axis count: MAX_AXES fixes the port layout, NUM_AXES the active axes.
    localparam int JCSL_MAX_AXES = 6;
    localparam int JCSL_NUM_AXES = 6;

    // Configuration register indexes.
    localparam logic [2:0] JCSL_REG_DEV_LAST = 3'd5;
    localparam logic [2:0] JCSL_REG_ACCEL    = 3'd6;

    localparam logic [23:0] JCSL_DEV_RESET   = 24'd3277;
    localparam logic [31:0] JCSL_ACCEL_RESET = 32'd100000;

    // Result case codes.
    localparam logic [1:0] JCSL_CODE_NORMAL   = 2'd0;
    localparam logic [1:0] JCSL_CODE_STRAIGHT = 2'd1;
    localparam logic [1:0] JCSL_CODE_REVERSAL = 2'd2;
    localparam logic [1:0] JCSL_CODE_NULLVEC  = 2'd3;

    // 0.99 in Q30 scaled by 100: 99 * 2^30.
    localparam logic signed [41:0] JCSL_COS_LIM = 42'sd106300440576;
    localparam logic signed [35:0] JCSL_Q30_ONE = 36'sd1073741824;

    localparam logic [31:0] JCSL_SPEED_CEIL    = 32'd2560000000;
    localparam logic [67:0] JCSL_SPEED_CEIL_SQ = 68'd6553600000000000000;

    // Pipeline geometry.
    localparam int JCSL_SQRT_STAGES = 32;
    localparam int JCSL_DIV_STAGES  = 42;
    localparam int JCSL_POS_DELTA   = JCSL_SQRT_STAGES;
    localparam int JCSL_POS_MUL     = JCSL_POS_DELTA + 1;
    localparam int JCSL_POS_DIV_END = JCSL_POS_MUL + JCSL_DIV_STAGES;
    localparam int JCSL_POS_MUL2    = JCSL_POS_DIV_END + 1;
    localparam int JCSL_POS_SUM     = JCSL_POS_MUL2 + 1;
    localparam int JCSL_POS_LAST    = JCSL_POS_SUM + JCSL_SQRT_STAGES;
    localparam int JCSL_SIDE_LEN    = JCSL_POS_LAST + 1;

    // Control that travels beside the datapath.
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
        logic       sat;
    } jcsl_side_t;

endpackage

`default_nettype wire

[rtl/jcsl_sqrt.sv]
// ----------------------------------------------------------------------------
// jcsl_sqrt
// Pipelined integer square root, 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jcsl_sqrt (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] x_in,
    output logic      [31:0] root_out
);

    localparam int N = jcsl_pkg::JCSL_SQRT_STAGES;

    logic [63:0] x_reg    [N];
    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];

    logic [63:0] x_next    [N];
    logic [33:0] rem_next  [N];
    logic [31:0] root_next [N];

    always_comb begin
        logic [63:0] xs;
        logic [33:0] rs;
        logic [31:0] qs;
        logic [35:0] rem_w;
        logic [35:0] trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                xs = x_in;
                rs = '0;
                qs = '0;
            end else begin
                xs = x_reg[k-1];
                rs = rem_reg[k-1];
                qs = root_reg[k-1];
            end
            rem_w = {rs, xs[63:62]};
            trial = {2'b00, qs, 2'b01};
            if (rem_w >= trial) begin
                rem_next[k]  = 34'(rem_w - trial);
                root_next[k] = {qs[30:0], 1'b1};
            end else begin
                rem_next[k]  = rem_w[33:0];
                root_next[k] = {qs[30:0], 1'b0};
            end
            x_next[k] = {xs[61:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_out = root_reg[N-1];

endmodule

`default_nettype wire

[rtl/jcsl_div.sv]
// ----------------------------------------------------------------------------
// jcsl_div
// Pipelined restoring divider: 62-bit numerator, 30-bit divisor, 42-bit
// quotient, one quotient bit per stage. Numerator >> 42 must be below divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module jcsl_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [61:0] num_in,
    input  wire logic [29:0] den_in,
    output logic      [41:0] quo_out
);

    localparam int N = jcsl_pkg::JCSL_DIV_STAGES;

    logic [29:0] rem_reg [N];
    logic [41:0] q_reg   [N];
    logic [41:0] n_reg   [N];
    logic [29:0] d_reg   [N];

    logic [29:0] rem_next [N];
    logic [41:0] q_next   [N];
    logic [41:0] n_next   [N];

    always_comb begin
        logic [29:0] rs;
        logic [41:0] qs;
        logic [41:0] ns;
        logic [29:0] ds;
        logic [30:0] rem_w;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rs = {10'b0, num_in[61:42]};
                qs = '0;
                ns = num_in[41:0];
                ds = den_in;
            end else begin
                rs = rem_reg[k-1];
                qs = q_reg[k-1];
                ns = n_reg[k-1];
                ds = d_reg[k-1];
            end
            rem_w = {rs, ns[41]};
            if (rem_w >= {1'b0, ds}) begin
                rem_next[k] = 30'(rem_w - {1'b0, ds});
                q_next[k]   = {qs[40:0], 1'b1};
            end else begin
                rem_next[k] = rem_w[29:0];
                q_next[k]   = {qs[40:0], 1'b0};
            end
            n_next[k] = {ns[40:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                n_reg[k]   <= n_next[k];
                d_reg[k]   <= (k == 0) ? den_in : d_reg[k-1];
            end
        end
    end

    assign quo_out = q_reg[N-1];

endmodule

`default_nettype wire

[rtl/jcsl_front.sv]
// ----------------------------------------------------------------------------
// jcsl_front
// Three-stage front end: products, dot product and squared axis terms,
// then sums, angle classification and the half-angle radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module jcsl_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [jcsl_pkg::JCSL_MAX_AXES-1:0][15:0] a_comp,
    input  wire logic [jcsl_pkg::JCSL_MAX_AXES-1:0][15:0] b_comp,
    input  wire logic [jcsl_pkg::JCSL_MAX_AXES-1:0][23:0] dev,
    output jcsl_pkg::jcsl_side_t       side_out,
    output logic [63:0]                sum_a_out,
    output logic [63:0]                sum_b_out,
    output logic [63:0]                h_sq_out
);

    localparam int NA = jcsl_pkg::JCSL_NUM_AXES;

    // stage 1
    logic                v1_reg;
    logic signed [31:0]  ab_reg [NA];
    logic        [39:0]  pa_reg [NA];
    logic        [39:0]  pb_reg [NA];
    // stage 2
    logic                v2_reg;
    logic signed [34:0]  dot_reg;
    logic        [59:0]  sqa_reg [NA];
    logic        [59:0]  sqb_reg [NA];
    logic                nz_a_reg;
    logic                nz_b_reg;
    // stage 3
    logic                v3_reg;
    logic        [1:0]   code3_reg;
    logic        [62:0]  sum_a_reg;
    logic        [62:0]  sum_b_reg;
    logic        [29:0]  h_reg;

    logic signed [31:0]  ab_next [NA];
    logic        [39:0]  pa_next [NA];
    logic        [39:0]  pb_next [NA];
    logic signed [34:0]  dot_next;
    logic        [59:0]  sqa_next [NA];
    logic        [59:0]  sqb_next [NA];
    logic                nz_a_next;
    logic                nz_b_next;
    logic        [62:0]  sum_a_next;
    logic        [62:0]  sum_b_next;
    logic signed [34:0]  cos_w;
    logic signed [41:0]  c100_w;
    logic signed [35:0]  h_w;
    logic        [1:0]   code_next;

    always_comb begin
        logic [15:0] abs_a;
        logic [15:0] abs_b;
        for (int i = 0; i < NA; i++) begin
            abs_a = a_comp[i][15] ? 16'(~a_comp[i] + 16'd1) : a_comp[i];
            abs_b = b_comp[i][15] ? 16'(~b_comp[i] + 16'd1) : b_comp[i];
            ab_next[i] = $signed(a_comp[i]) * $signed(b_comp[i]);
            pa_next[i] = 40'(abs_a) * 40'(dev[i]);
            pb_next[i] = 40'(abs_b) * 40'(dev[i]);
        end
    end

    always_comb begin
        dot_next  = '0;
        nz_a_next = 1'b0;
        nz_b_next = 1'b0;
        for (int i = 0; i < NA; i++) begin
            dot_next    = dot_next + 35'(ab_reg[i]);
            // terms fit 30 bits after dropping 9 fraction bits
            sqa_next[i] = 60'(pa_reg[i][38:9]) * 60'(pa_reg[i][38:9]);
            sqb_next[i] = 60'(pb_reg[i][38:9]) * 60'(pb_reg[i][38:9]);
            nz_a_next   = nz_a_next | (pa_reg[i] != '0);
            nz_b_next   = nz_b_next | (pb_reg[i] != '0);
        end
    end

    always_comb begin
        sum_a_next = '0;
        sum_b_next = '0;
        for (int i = 0; i < NA; i++) begin
            sum_a_next = sum_a_next + 63'(sqa_reg[i]);
            sum_b_next = sum_b_next + 63'(sqb_reg[i]);
        end
        cos_w  = -dot_reg;
        c100_w = 42'(cos_w) * 42'sd100;
        h_w    = (jcsl_pkg::JCSL_Q30_ONE - 36'(cos_w)) >>> 1;
        if (c100_w < -jcsl_pkg::JCSL_COS_LIM) begin
            code_next = jcsl_pkg::JCSL_CODE_STRAIGHT;
        end else if (c100_w > jcsl_pkg::JCSL_COS_LIM) begin
            code_next = jcsl_pkg::JCSL_CODE_REVERSAL;
        end else if (!nz_a_reg || !nz_b_reg) begin
            code_next = jcsl_pkg::JCSL_CODE_NULLVEC;
        end else begin
            code_next = jcsl_pkg::JCSL_CODE_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                ab_reg[i]  <= ab_next[i];
                pa_reg[i]  <= pa_next[i];
                pb_reg[i]  <= pb_next[i];
                sqa_reg[i] <= sqa_next[i];
                sqb_reg[i] <= sqb_next[i];
            end
            dot_reg   <= dot_next;
            nz_a_reg  <= nz_a_next;
            nz_b_reg  <= nz_b_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            h_reg     <= h_w[29:0];
            code3_reg <= code_next;
        end
    end

    // valid, code, sat from the top bit down
    assign side_out  = {v3_reg, code3_reg, 1'b0};
    assign sum_a_out = {1'b0, sum_a_reg};
    assign sum_b_out = {1'b0, sum_b_reg};
    assign h_sq_out  = {4'b0, h_reg, 30'b0};

endmodule

`default_nettype wire

[rtl/junction_corner_speed_limit.sv]
// ----------------------------------------------------------------------------
// junction_corner_speed_limit
// Cornering speed limit at a junction of two moves (junction deviation).
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries twelve signed Q1.15 components, the previous
// move's unit vector then the next move's. Result stream: m_tdata carries the
// corner speed (velocity * 256), m_tuser the case code.
// Config channel: cfg_index picks a register (0..5 per-axis deviation,
// 6 centripetal accel), written when cfg_valid and cfg_ready are high; index
// 7 is dropped. Write only while the pipeline is empty.
// Throughput: one item per cycle while the skid register is empty; a fixed
// pipeline of three front stages, 32-stage root extractors for the norms, the
// half-angle sine and the speed, a 42-stage divider and multiply/add stages.
// Reset: aresetn (sync, active low) drops all valid bits and loads the
// register defaults. Stall: a skid register behind the output register
// catches one result; while it is full the whole pipeline freezes and
// s_tready is low, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module junction_corner_speed_limit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // a_comp_0..5, b_comp_0..5, 16 bits each from bit 0 up
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,
    // corner_speed
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [31:0]  m_tdata,
    // case_code
    output logic      [1:0]   m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int MA = jcsl_pkg::JCSL_MAX_AXES;

    // ---------------- configuration registers ----------------
    logic [MA-1:0][23:0] dev_reg;
    logic [31:0]         accel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MA; i++) begin
                dev_reg[i] <= jcsl_pkg::JCSL_DEV_RESET;
            end
            accel_reg <= jcsl_pkg::JCSL_ACCEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index <= jcsl_pkg::JCSL_REG_DEV_LAST) begin
                dev_reg[cfg_index] <= cfg_data[23:0];
            end else if (cfg_index == jcsl_pkg::JCSL_REG_ACCEL) begin
                accel_reg <= cfg_data;
            end
        end
    end

    // ---------------- pipeline enable ----------------
    // Everything advances together unless the skid register is holding.
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- front end ----------------
    logic [MA-1:0][15:0] a_comp;
    logic [MA-1:0][15:0] b_comp;
    always_comb begin
        for (int i = 0; i < MA; i++) begin
            a_comp[i] = s_tdata[16*i +: 16];
            b_comp[i] = s_tdata[16*(MA+i) +: 16];
        end
    end

    jcsl_pkg::jcsl_side_t front_side;
    logic [63:0] sum_a, sum_b, h_sq;

    jcsl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .a_comp    (a_comp),
        .b_comp    (b_comp),
        .dev       (dev_reg),
        .side_out  (front_side),
        .sum_a_out (sum_a),
        .sum_b_out (sum_b),
        .h_sq_out  (h_sq)
    );

    // ---------------- norms and half-angle sine ----------------
    logic [31:0] norm_a, norm_b, s_root;

    jcsl_sqrt u_sqrt_a (.aclk(aclk), .en(en), .x_in(sum_a), .root_out(norm_a));
    jcsl_sqrt u_sqrt_b (.aclk(aclk), .en(en), .x_in(sum_b), .root_out(norm_b));
    jcsl_sqrt u_sqrt_s (.aclk(aclk), .en(en), .x_in(h_sq),  .root_out(s_root));

    // ---------------- side band: valid, case code, saturation ----------------
    jcsl_pkg::jcsl_side_t side_reg [jcsl_pkg::JCSL_SIDE_LEN];
    logic sat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < jcsl_pkg::JCSL_SIDE_LEN; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= front_side;
            for (int k = 1; k < jcsl_pkg::JCSL_SIDE_LEN; k++) begin
                if (k == jcsl_pkg::JCSL_POS_SUM) begin
                    side_reg[k].valid <= side_reg[k-1].valid;
                    side_reg[k].code  <= side_reg[k-1].code;
                    side_reg[k].sat   <= sat_next;
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // ---------------- delta, numerator, divisor ----------------
    logic [31:0] delta_reg;
    logic [29:0] s_reg;
    logic [29:0] den_reg;
    logic [61:0] num_reg;
    logic [29:0] den2_reg;
    logic [30:0] den_next;

    // s stays below 1.0 outside the straight/reversal cases
    assign den_next = 31'(jcsl_pkg::JCSL_Q30_ONE) - {1'b0, s_root[29:0]};

    always_ff @(posedge aclk) begin
        if (en) begin
            delta_reg <= 32'((33'(norm_a) + 33'(norm_b)) >> 1);
            s_reg     <= s_root[29:0];
            den_reg   <= den_next[29:0];
            num_reg   <= 62'(delta_reg) * 62'(s_reg);
            den2_reg  <= den_reg;
        end
    end

    // ---------------- corner radius R = delta * s / (1 - s) ----------------
    logic [41:0] rad;

    jcsl_div u_div (
        .aclk    (aclk),
        .en      (en),
        .num_in  (num_reg),
        .den_in  (den2_reg),
        .quo_out (rad)
    );

    // ---------------- R * accel / 64 with saturation test ----------------
    // q = R >> 6 split in two halves to keep each multiplier narrow.
    logic [49:0] qa_hi_reg, qa_lo_reg;
    logic [37:0] ra_reg;
    logic [63:0] y_reg;
    logic [67:0] qa_w;
    logic [67:0] y_w;

    always_comb begin
        qa_w     = {qa_hi_reg, 18'b0} + 68'(qa_lo_reg);
        y_w      = qa_w + 68'(ra_reg[37:6]);
        sat_next = qa_w > jcsl_pkg::JCSL_SPEED_CEIL_SQ;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_hi_reg <= 50'(rad[41:24]) * 50'(accel_reg);
            qa_lo_reg <= 50'(rad[23:6]) * 50'(accel_reg);
            ra_reg    <= 38'(rad[5:0]) * 38'(accel_reg);
            y_reg     <= y_w[63:0];
        end
    end

    logic [31:0] speed_root;
    jcsl_sqrt u_sqrt_v (.aclk(aclk), .en(en), .x_in(y_reg), .root_out(speed_root));

    // ---------------- result select ----------------
    jcsl_pkg::jcsl_side_t last_side;
    logic [31:0] res_speed;

    assign last_side = side_reg[jcsl_pkg::JCSL_POS_LAST];

    always_comb begin
        case (last_side.code)
            jcsl_pkg::JCSL_CODE_NORMAL: begin
                if (last_side.sat || speed_root > jcsl_pkg::JCSL_SPEED_CEIL) begin
                    res_speed = jcsl_pkg::JCSL_SPEED_CEIL;
                end else begin
                    res_speed = speed_root;
                end
            end
            jcsl_pkg::JCSL_CODE_STRAIGHT: res_speed = jcsl_pkg::JCSL_SPEED_CEIL;
            default:                      res_speed = '0;
        endcase
    end

    // ---------------- output register and skid ----------------
    logic        out_valid_reg;
    logic [31:0] out_speed_reg;
    logic [1:0]  out_code_reg;
    logic [31:0] skid_speed_reg;
    logic [1:0]  skid_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // pipeline frozen; drain skid into the output register
            if (m_tready || !out_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_speed_reg  <= skid_speed_reg;
                out_code_reg   <= skid_code_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg <= last_side.valid;
            out_speed_reg <= res_speed;
            out_code_reg  <= last_side.code;
        end else if (last_side.valid) begin
            skid_valid_reg <= 1'b1;
            skid_speed_reg <= res_speed;
            skid_code_reg  <= last_side.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_speed_reg;
    assign m_tuser  = out_code_reg;

    // ---------------- assertions ----------------
    skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transfer while output register is empty");

    skid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("skid transfer dropped during stall");

    straight_at_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_code_reg == jcsl_pkg::JCSL_CODE_STRAIGHT
            |-> out_speed_reg == jcsl_pkg::JCSL_SPEED_CEIL)
        else $error("straight junction not at ceiling");

    zero_cases: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_code_reg == jcsl_pkg::JCSL_CODE_REVERSAL ||
                          out_code_reg == jcsl_pkg::JCSL_CODE_NULLVEC)
            |-> out_speed_reg == '0)
        else $error("reversal or null vector with nonzero speed");

    speed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_speed_reg <= jcsl_pkg::JCSL_SPEED_CEIL)
        else $error("corner speed above ceiling");

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the junction corner speed limit pipeline: directed
// corner cases from a table, then random junctions under random idling on
// both streams, with each result compared against its typed table entry or a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import jcsl_pkg::*;

    localparam int LATENCY = 114;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    junction_corner_speed_limit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [31:0] speed;
        logic [1:0]  code;
    } corner_t;

    // Directed junction: one vector pair, optional typed-in expectation.
    typedef struct {
        logic [191:0] comps;
        logic         typed;
        logic [31:0]  speed;
        logic [1:0]   code;
    } junction_row_t;

    logic [23:0] dev_mirror [JCSL_MAX_AXES];
    logic [31:0] accel_mirror;
    corner_t     pending_corners [$];
    int          mismatch_count = 0;
    int          corners_seen = 0;
    int          sent_count = 0;
    int          code_hist [4] = '{0, 0, 0, 0};
    logic        stim_done = 1'b0;

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Expected corner speed and case code for one vector pair.
    function automatic corner_t corner_speed_of(logic [191:0] comps);
        corner_t c;
        logic signed [15:0] a, b;
        logic signed [63:0] dot, cosq;
        logic [63:0] sum_a, sum_b, pa, pb, delta, h, s, rad, q, r, y;
        logic nz_a, nz_b;
        dot = 0; sum_a = 0; sum_b = 0; nz_a = 0; nz_b = 0;
        for (int i = 0; i < JCSL_NUM_AXES; i++) begin
            a = comps[16*i +: 16];
            b = comps[16*(JCSL_MAX_AXES+i) +: 16];
            dot += 64'(a) * 64'(b);
        end
        cosq = -dot;
        if (cosq * 100 < -64'sd99 * (64'sd1 << 30)) begin
            c.speed = JCSL_SPEED_CEIL; c.code = JCSL_CODE_STRAIGHT;
            return c;
        end
        if (cosq * 100 > 64'sd99 * (64'sd1 << 30)) begin
            c.speed = 0; c.code = JCSL_CODE_REVERSAL;
            return c;
        end
        for (int i = 0; i < JCSL_NUM_AXES; i++) begin
            a = comps[16*i +: 16];
            b = comps[16*(JCSL_MAX_AXES+i) +: 16];
            pa = 64'(a < 0 ? -32'(a) : 32'(a)) * dev_mirror[i];
            pb = 64'(b < 0 ? -32'(b) : 32'(b)) * dev_mirror[i];
            if (pa != 0) nz_a = 1;
            if (pb != 0) nz_b = 1;
            pa >>= 9; pb >>= 9;
            sum_a += pa * pa; sum_b += pb * pb;
        end
        if (!nz_a || !nz_b) begin
            c.speed = 0; c.code = JCSL_CODE_NULLVEC;
            return c;
        end
        delta = (root64(sum_a) + root64(sum_b)) >> 1;
        h = 64'((64'sd1 << 30) - cosq) >> 1;
        s = root64(h << 30);
        rad = (delta * s) / ((64'd1 << 30) - s);
        q = rad >> 6;
        r = rad & 64'd63;
        c.code = JCSL_CODE_NORMAL;
        if (q != 0 && 64'(accel_mirror) > 64'd6553600000000000000 / q) begin
            c.speed = JCSL_SPEED_CEIL;
        end else begin
            y = root64(q * accel_mirror + ((r * accel_mirror) >> 6));
            c.speed = (y > 64'(JCSL_SPEED_CEIL)) ? JCSL_SPEED_CEIL : y[31:0];
        end
        return c;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= JCSL_REG_DEV_LAST) dev_mirror[idx] = val[23:0];
        else if (idx == JCSL_REG_ACCEL) accel_mirror = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Block must be empty before a config write.
    task automatic drain_pipeline();
        while (pending_corners.size() != 0) @(negedge aclk);
        idle_cycles(4);
    endtask

    task automatic send_junction(logic [191:0] comps, logic typed, corner_t want,
                                 logic no_gap = 1'b0);
        corner_t c;
        int gap;
        gap = 0;
        if (!no_gap && $urandom_range(0, 3) != 0) gap = $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_tvalid <= 1'b1;
        s_tdata <= comps;
        do @(posedge aclk); while (!s_tready);
        c = corner_speed_of(comps);
        if (typed && (c.speed !== want.speed || c.code !== want.code))
            $error("table row disagrees with predictor: speed %0d code %0d",
                   c.speed, c.code);
        pending_corners.push_back(typed ? want : c);
        sent_count++;
        @(negedge aclk);
    endtask

    // Mostly components within +/-13000: a random direction for the previous move, the
    // next move close to it, opposite, or unrelated, with axes sometimes zero.
    function automatic logic [191:0] random_junction();
        logic [191:0] v;
        logic signed [15:0] a;
        int mode, mask;
        v = '0;
        mode = $urandom_range(0, 9);
        mask = $urandom_range(1, 63);
        if (mode == 0) begin
            for (int i = 0; i < 6; i++) v[32*i +: 32] = $urandom();
            return v;
        end
        for (int i = 0; i < JCSL_MAX_AXES; i++) begin
            a = mask[i] ? 16'($urandom_range(0, 26000)) - 16'sd13000 : 16'sd0;
            v[16*i +: 16] = a;
            case (mode)
                1, 2:    v[16*(6+i) +: 16] = -a + 16'($urandom_range(0, 60)) - 16'sd30;
                3:       v[16*(6+i) +: 16] = a + 16'($urandom_range(0, 400)) - 16'sd200;
                4:       v[16*(6+i) +: 16] = mask[i] ? 16'sd0 : 16'($urandom());
                default: v[16*(6+i) +: 16] = 16'($urandom_range(0, 26000)) - 16'sd13000;
            endcase
        end
        return v;
    endfunction

    // Result side: random stall per item, compare against oldest expectation.
    initial begin : result_checker
        corner_t want;
        int stall;
        forever begin
            @(negedge aclk);
            stall = 0;
            if ($urandom_range(0, 3) != 0) stall = $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                idle_cycles(stall);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            corners_seen++;
            if (pending_corners.size() == 0) begin
                $error("corner result with no pending junction");
                mismatch_count++;
            end else begin
                want = pending_corners.pop_front();
                code_hist[want.code]++;
                if (m_tdata !== want.speed) begin
                    $error("corner_speed: expected %0d, actual %0d", want.speed, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.code) begin
                    $error("case_code: expected %0d, actual %0d", want.code, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    junction_row_t directed_rows [$];

    function automatic logic [191:0] pair(logic signed [15:0] a0, logic signed [15:0] a1,
                                          logic signed [15:0] b0, logic signed [15:0] b1);
        logic [191:0] v;
        v = '0;
        v[15:0] = a0; v[31:16] = a1; v[111:96] = b0; v[127:112] = b1;
        return v;
    endfunction

    initial begin : stimulus
        corner_t want, none;
        none.speed = 0; none.code = JCSL_CODE_NORMAL;
        for (int i = 0; i < JCSL_MAX_AXES; i++) dev_mirror[i] = JCSL_DEV_RESET;
        accel_mirror = JCSL_ACCEL_RESET;

        // reversal: b equals -a
        directed_rows.push_back('{pair(16'sd32767, 0, -16'sd32767, 0), 1,
                                  32'd0, JCSL_CODE_REVERSAL});
        // straight: b equals a (last row: b near -a, a reversal)
        directed_rows.push_back('{pair(16'sd32767, 0, 16'sd32767, 0), 1,
                                  JCSL_SPEED_CEIL, JCSL_CODE_STRAIGHT});
        directed_rows.push_back('{pair(-16'sd32768, 0, -16'sd32768, 0), 1,
                                  JCSL_SPEED_CEIL, JCSL_CODE_STRAIGHT});
        directed_rows.push_back('{pair(-16'sd32768, 0, 16'sd32767, 0), 1,
                                  32'd0, JCSL_CODE_REVERSAL});
        // null vectors on either side
        directed_rows.push_back('{pair(0, 0, 0, 16'sd32767), 1, 32'd0, JCSL_CODE_NULLVEC});
        directed_rows.push_back('{pair(16'sd32767, 0, 0, 0), 1, 32'd0, JCSL_CODE_NULLVEC});
        directed_rows.push_back('{'0, 1, 32'd0, JCSL_CODE_NULLVEC});
        // right angle, 45 and 135 degree corners, then full-scale and all-ones patterns
        directed_rows.push_back('{pair(16'sd32767, 0, 0, 16'sd32767), 0, 0, 0});
        directed_rows.push_back('{pair(16'sd23170, 16'sd23170, 16'sd32767, 0), 0, 0, 0});
        directed_rows.push_back('{pair(16'sd23170, 16'sd23170, -16'sd32767, 0), 0, 0, 0});
        directed_rows.push_back('{pair(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768),
                                  0, 0, 0});
        directed_rows.push_back('{{192{1'b1}}, 0, 0, 0});
        directed_rows.push_back('{{12{16'h8000}}, 0, 0, 0});
        directed_rows.push_back('{{12{16'h7fff}}, 0, 0, 0});
        directed_rows.push_back('{{6{16'h7fff, 16'h8000}}, 0, 0, 0});

        idle_cycles(5);
        aresetn <= 1'b1;
        idle_cycles(2);

        foreach (directed_rows[k]) begin
            want.speed = directed_rows[k].speed; want.code = directed_rows[k].code;
            send_junction(directed_rows[k].comps, directed_rows[k].typed, want);
        end
        s_tvalid <= 1'b0;

        // Several register settings: extremes first, then random phases.
        for (int phase = 0; phase < 8; phase++) begin
            drain_pipeline();
            for (int r = 0; r <= JCSL_REG_ACCEL; r++) begin
                case (phase)
                    0: write_reg(3'(r), 32'hffffffff);
                    1: write_reg(3'(r), 32'd0);
                    2: write_reg(3'(r), (r == JCSL_REG_ACCEL) ? 32'd1 : 32'd1);
                    3: write_reg(3'(r), (r == 2) ? 32'd0 : $urandom());
                    default: write_reg(3'(r), (r == JCSL_REG_ACCEL) ?
                                       $urandom_range(1000, 5000000) :
                                       $urandom_range(0, 200000));
                endcase
            end
            if (phase == 4) write_reg(3'd7, $urandom()); // dropped index
            for (int n = 0; n < 130; n++) begin
                send_junction(random_junction(), 1'b0, none, n % 40 < 10);
                // hold off until every result is in, once per phase
                if (n == 60) begin
                    s_tvalid <= 1'b0;
                    drain_pipeline();
                end
            end
            s_tvalid <= 1'b0;
        end

        while (pending_corners.size() != 0) @(negedge aclk);
        idle_cycles(LATENCY + 20);
        stim_done = 1'b1;
        $display("Sent %0d junctions over 8 register settings, checked %0d results",
                 sent_count, corners_seen);
        $display("Cases: normal %0d, straight %0d, reversal %0d, null %0d",
                 code_hist[0], code_hist[1], code_hist[2], code_hist[3]);
        if (mismatch_count == 0 && pending_corners.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Worst case: ~1100 items, each with random gaps and stalls, plus drains.
    initial begin : watchdog
        #3000000;
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

[junction_corner_speed_limit.f]
rtl/jcsl_pkg.sv
rtl/jcsl_sqrt.sv
rtl/jcsl_div.sv
rtl/jcsl_front.sv
rtl/junction_corner_speed_limit.sv
verif/testbench.sv
